>>> hw/rtl/tcce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Screen geometry, field widths, character codes, command and state codes,
// and the control and status bundles shared by the controller and datapath.
// ----------------------------------------------------------------------------
package tcce_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = ROWS * COLUMNS;

   localparam int CMD_W   = 3;
   localparam int CH_W    = 8;
   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int POS_W   = 11;
   localparam int CELL_W  = 16;
   localparam int COLOR_W = 8;

   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int CNT_W  = $clog2(CELL_COUNT + COLUMNS + 1);

   localparam int TAB_STEP = 4;

   localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd7;

   localparam logic [CH_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CH_W-1:0] CH_TAB       = 8'd9;
   localparam logic [CH_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CH_W-1:0] CH_RETURN    = 8'd13;
   localparam logic [CH_W-1:0] CH_BLANK     = 8'h20;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT_CHAR   = 3'd0,
      CMD_CLEAR      = 3'd1,
      CMD_SET_CURSOR = 3'd2,
      CMD_PUT_AT     = 3'd3,
      CMD_READ_CELL  = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_CLEAR,
      ST_SCROLL,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      SW_NONE,
      SW_ZERO,
      SW_BLANK,
      SW_SCROLL
   } sweep_type;

   typedef struct packed {
      logic      take_req;
      logic      exec;
      sweep_type sweep;
      logic      load_rsp;
   } ctl_type;

   typedef struct packed {
      logic need_clear;
      logic need_scroll;
      logic sweep_last;
      logic rsp_busy;
   } sts_type;

endpackage

>>> hw/rtl/tcce_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console controller
// Sequences the reset clearing pass, command execution, clear and scroll
// sweeps, and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module tcce_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcce_pkg::sts_type sts,
   output tcce_pkg::ctl_type ctl
);

   tcce_pkg::state_type state_ff;
   tcce_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcce_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcce_pkg::ST_INIT: begin
            if (sts.sweep_last) state_in = tcce_pkg::ST_IDLE;
         end
         tcce_pkg::ST_IDLE: begin
            if (req_valid) state_in = tcce_pkg::ST_EXEC;
         end
         tcce_pkg::ST_EXEC: begin
            priority if (sts.need_clear) state_in = tcce_pkg::ST_CLEAR;
            else if (sts.need_scroll) state_in = tcce_pkg::ST_SCROLL;
            else state_in = tcce_pkg::ST_RESP;
         end
         tcce_pkg::ST_CLEAR: begin
            if (sts.sweep_last) state_in = tcce_pkg::ST_RESP;
         end
         tcce_pkg::ST_SCROLL: begin
            if (sts.sweep_last) state_in = tcce_pkg::ST_RESP;
         end
         tcce_pkg::ST_RESP: begin
            if (!sts.rsp_busy) state_in = tcce_pkg::ST_IDLE;
         end
         default: state_in = tcce_pkg::ST_INIT;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      ctl.take_req = 1'b0;
      ctl.exec     = 1'b0;
      ctl.sweep    = tcce_pkg::SW_NONE;
      ctl.load_rsp = 1'b0;
      unique case (state_ff)
         tcce_pkg::ST_INIT: begin
            ctl.sweep = tcce_pkg::SW_ZERO;
         end
         tcce_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            ctl.take_req = req_valid;
         end
         tcce_pkg::ST_EXEC: begin
            ctl.exec = 1'b1;
         end
         tcce_pkg::ST_CLEAR: begin
            ctl.sweep = tcce_pkg::SW_BLANK;
         end
         tcce_pkg::ST_SCROLL: begin
            ctl.sweep = tcce_pkg::SW_SCROLL;
         end
         tcce_pkg::ST_RESP: begin
            ctl.load_rsp = !sts.rsp_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

>>> hw/rtl/tcce_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console datapath
// Holds the screen memory, cursor, color register, sweep counter, request
// latch and result register, and carries out the commands of the controller.
// ----------------------------------------------------------------------------
module tcce_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  tcce_pkg::ctl_type              ctl,
   output tcce_pkg::sts_type              sts,
   input  logic [tcce_pkg::CMD_W-1:0]     req_cmd,
   input  logic [tcce_pkg::CH_W-1:0]      req_ch,
   input  logic [tcce_pkg::ROW_W-1:0]     req_row,
   input  logic [tcce_pkg::COL_W-1:0]     req_col,
   input  logic                           csr_we,
   input  logic [tcce_pkg::COLOR_W-1:0]   csr_wdata,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [tcce_pkg::ROW_W-1:0]     rsp_cursor_row,
   output logic [tcce_pkg::COL_W-1:0]     rsp_cursor_col,
   output logic [tcce_pkg::POS_W-1:0]     rsp_cursor_pos,
   output logic [tcce_pkg::CELL_W-1:0]    rsp_cell_data
);

   localparam int RW = tcce_pkg::ROW_W;
   localparam int CW = tcce_pkg::COL_W;
   localparam int AW = tcce_pkg::ADDR_W;
   localparam int NW = tcce_pkg::CNT_W;

   logic [tcce_pkg::CELL_W-1:0] mem [tcce_pkg::CELL_COUNT];

   logic [tcce_pkg::COLOR_W-1:0] color_ff, color_in;
   logic [tcce_pkg::CMD_W-1:0]   cmd_ff;
   logic [tcce_pkg::CH_W-1:0]    ch_ff;
   logic [RW-1:0]                row_ff;
   logic [CW-1:0]                col_ff;
   logic [RW-1:0]                cur_row_ff, cur_row_in;
   logic [CW-1:0]                cur_col_ff, cur_col_in;
   logic [NW-1:0]                cnt_ff, cnt_in;
   logic [tcce_pkg::CELL_W-1:0]  rd_data_ff;
   logic                         rd_hit_ff, rd_hit_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0]                rsp_row_ff;
   logic [CW-1:0]                rsp_col_ff;
   logic [tcce_pkg::POS_W-1:0]   rsp_pos_ff;
   logic [tcce_pkg::CELL_W-1:0]  rsp_data_ff;

   logic [CW:0]                 col_a;
   logic [RW:0]                 row_a;
   logic                        pc_we;
   logic [CW-1:0]               pc_col;
   logic [tcce_pkg::CH_W-1:0]   pc_char;
   logic                        scroll_need;
   logic                        in_bounds;
   logic [AW-1:0]               cur_addr;
   logic [AW-1:0]               tgt_addr;
   logic [AW-1:0]               cur_pos;
   logic [NW-1:0]               cnt_m1;
   logic [NW-1:0]               src_cnt;
   logic [tcce_pkg::CELL_W-1:0] blank_cell;

   logic                        mem_we;
   logic [AW-1:0]               mem_waddr;
   logic [tcce_pkg::CELL_W-1:0] mem_wdata;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;

   // Put character: cursor motion, wrap at the right edge, scroll detection.
   always_comb begin
      col_a   = {1'b0, cur_col_ff};
      row_a   = {1'b0, cur_row_ff};
      pc_we   = 1'b0;
      pc_col  = cur_col_ff;
      pc_char = ch_ff;
      unique case (ch_ff)
         tcce_pkg::CH_NEWLINE: begin
            col_a = '0;
            row_a = row_a + 1'b1;
         end
         tcce_pkg::CH_RETURN: begin
            col_a = '0;
         end
         tcce_pkg::CH_TAB: begin
            col_a = (col_a + (CW + 1)'(tcce_pkg::TAB_STEP))
                  & ~(CW + 1)'(tcce_pkg::TAB_STEP - 1);
         end
         tcce_pkg::CH_BACKSPACE: begin
            if (cur_col_ff != '0) begin
               col_a   = col_a - 1'b1;
               pc_we   = 1'b1;
               pc_col  = cur_col_ff - 1'b1;
               pc_char = tcce_pkg::CH_BLANK;
            end
         end
         default: begin
            pc_we = 1'b1;
            col_a = col_a + 1'b1;
         end
      endcase
      if (col_a >= (CW + 1)'(tcce_pkg::COLUMNS)) begin
         col_a = '0;
         row_a = row_a + 1'b1;
      end
   end

   assign scroll_need = row_a >= (RW + 1)'(tcce_pkg::ROWS);
   assign in_bounds = ({1'b0, row_ff} < (RW + 1)'(tcce_pkg::ROWS))
                   && ({1'b0, col_ff} < (CW + 1)'(tcce_pkg::COLUMNS));
   assign cur_addr = AW'(cur_row_ff) * AW'(tcce_pkg::COLUMNS) + AW'(pc_col);
   assign tgt_addr = AW'(row_ff) * AW'(tcce_pkg::COLUMNS) + AW'(col_ff);
   assign cur_pos  = AW'(cur_row_ff) * AW'(tcce_pkg::COLUMNS) + AW'(cur_col_ff);
   assign cnt_m1   = cnt_ff - 1'b1;
   assign src_cnt  = cnt_ff + NW'(tcce_pkg::COLUMNS);
   assign blank_cell = {color_ff, tcce_pkg::CH_BLANK};

   // Memory port control. A scroll reads one row ahead of the write pointer,
   // so every cell is read before it is overwritten.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cur_addr;
      mem_wdata = {color_ff, pc_char};
      rd_en     = 1'b0;
      rd_addr   = tgt_addr;
      unique case (ctl.sweep)
         tcce_pkg::SW_ZERO: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(cnt_ff);
            mem_wdata = '0;
         end
         tcce_pkg::SW_BLANK: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(cnt_ff);
            mem_wdata = blank_cell;
         end
         tcce_pkg::SW_SCROLL: begin
            rd_en     = 1'b1;
            rd_addr   = (src_cnt < NW'(tcce_pkg::CELL_COUNT)) ? AW'(src_cnt) : '0;
            mem_we    = cnt_ff != '0;
            mem_waddr = AW'(cnt_m1);
            mem_wdata = (cnt_m1 < NW'(tcce_pkg::CELL_COUNT - tcce_pkg::COLUMNS))
                      ? rd_data_ff : blank_cell;
         end
         default: begin
            if (ctl.exec) begin
               if (cmd_ff == tcce_pkg::CMD_PUT_CHAR) begin
                  mem_we = pc_we;
               end else if (cmd_ff == tcce_pkg::CMD_PUT_AT) begin
                  mem_we    = in_bounds;
                  mem_waddr = tgt_addr;
                  mem_wdata = {color_ff, ch_ff};
               end else if (cmd_ff == tcce_pkg::CMD_READ_CELL) begin
                  rd_en = in_bounds;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      rd_hit_in  = rd_hit_ff;
      if (ctl.exec) begin
         rd_hit_in = (cmd_ff == tcce_pkg::CMD_READ_CELL) && in_bounds;
         if (cmd_ff == tcce_pkg::CMD_PUT_CHAR) begin
            cur_col_in = col_a[CW-1:0];
            cur_row_in = scroll_need ? RW'(tcce_pkg::ROWS - 1) : row_a[RW-1:0];
         end else if (cmd_ff == tcce_pkg::CMD_CLEAR) begin
            cur_col_in = '0;
            cur_row_in = '0;
         end else if ((cmd_ff == tcce_pkg::CMD_SET_CURSOR) && in_bounds) begin
            cur_col_in = col_ff;
            cur_row_in = row_ff;
         end
      end
   end

   assign cnt_in   = (ctl.sweep != tcce_pkg::SW_NONE) ? cnt_ff + 1'b1 : '0;
   assign color_in = csr_we ? csr_wdata : color_ff;
   assign rsp_valid_in = ctl.load_rsp | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff     <= tcce_pkg::COLOR_RESET;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         cnt_ff       <= '0;
         rd_hit_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         color_ff     <= color_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         cnt_ff       <= cnt_in;
         rd_hit_ff    <= rd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.take_req) begin
         cmd_ff <= req_cmd;
         ch_ff  <= req_ch;
         row_ff <= req_row;
         col_ff <= req_col;
      end
      if (ctl.load_rsp) begin
         rsp_row_ff  <= cur_row_ff;
         rsp_col_ff  <= cur_col_ff;
         rsp_pos_ff  <= tcce_pkg::POS_W'(cur_pos);
         rsp_data_ff <= rd_hit_ff ? rd_data_ff : '0;
      end
   end

   always_comb begin
      sts.need_clear  = cmd_ff == tcce_pkg::CMD_CLEAR;
      sts.need_scroll = (cmd_ff == tcce_pkg::CMD_PUT_CHAR) && scroll_need;
      sts.sweep_last  = (ctl.sweep == tcce_pkg::SW_SCROLL)
                      ? (cnt_ff == NW'(tcce_pkg::CELL_COUNT))
                      : (cnt_ff == NW'(tcce_pkg::CELL_COUNT - 1));
      sts.rsp_busy    = rsp_valid_ff & ~rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_cell_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // The cursor never leaves the screen.
   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, cur_row_ff} < (RW + 1)'(tcce_pkg::ROWS))
      && ({1'b0, cur_col_ff} < (CW + 1)'(tcce_pkg::COLUMNS)))
      else $error("cursor outside the screen");

   // Every memory write lands inside the screen.
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ({1'b0, mem_waddr} < (AW + 1)'(tcce_pkg::CELL_COUNT)))
      else $error("screen write address out of range");

   // A new result is never loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |-> !(rsp_valid_ff && !rsp_ready))
      else $error("pending result overwritten");
`endif

endmodule

>>> hw/rtl/text_console_cursor_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor engine
// Character-cell screen of 16-bit cells with cursor control, scrolling and
// clearing, driven by one command per transaction.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Set cursor, put at position, read
// cell and a put character that does not scroll go through the execute and
// response states before the next accept. Clear adds a sweep that writes one
// screen cell per cycle, and a put character that scrolls adds a sweep that
// moves or blanks one cell per cycle through the separate read and write
// ports of the screen memory, with registered read data. After reset the
// screen memory is cleared to zero, during which req_ready is low; csr
// writes are taken at any time.
module text_console_cursor_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [tcce_pkg::CMD_W-1:0]     req_cmd,
   input  logic [tcce_pkg::CH_W-1:0]      req_ch,
   input  logic [tcce_pkg::ROW_W-1:0]     req_row,
   input  logic [tcce_pkg::COL_W-1:0]     req_col,
   input  logic                           csr_we,
   input  logic [tcce_pkg::COLOR_W-1:0]   csr_wdata,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [tcce_pkg::ROW_W-1:0]     rsp_cursor_row,
   output logic [tcce_pkg::COL_W-1:0]     rsp_cursor_col,
   output logic [tcce_pkg::POS_W-1:0]     rsp_cursor_pos,
   output logic [tcce_pkg::CELL_W-1:0]    rsp_cell_data
);

   tcce_pkg::ctl_type ctl;
   tcce_pkg::sts_type sts;

   tcce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   tcce_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .sts            (sts),
      .req_cmd        (req_cmd),
      .req_ch         (req_ch),
      .req_row        (req_row),
      .req_col        (req_col),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_data  (rsp_cell_data)
   );

endmodule

>>> sim/tb_text_console_cursor_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor engine testbench
// Drives console commands through the request channel and tracks the screen
// image, cursor and text color in a local model of the console. Each response
// is compared field by field with the oldest predicted cursor status. The
// request channel idles and the response channel stalls at random, and the
// text color is changed only while the engine is idle.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_engine;
   import tcce_pkg::*;

   localparam int CLK_HALF    = 10;
   localparam int QUIET_LIMIT = 10000;
   localparam int ROW_MAX     = (1 << ROW_W) - 1;
   localparam int COL_MAX     = (1 << COL_W) - 1;

   localparam logic [CMD_W-1:0] CMD_SPARE_LOW  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_HIGH = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [CH_W-1:0]  ch;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } console_cmd_type;

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [POS_W-1:0]  pos;
      logic [CELL_W-1:0] cell_data;
   } cursor_status_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd;
   logic [CH_W-1:0]     req_ch;
   logic [ROW_W-1:0]    req_row;
   logic [COL_W-1:0]    req_col;
   logic                csr_we;
   logic [COLOR_W-1:0]  csr_wdata;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [ROW_W-1:0]    rsp_cursor_row;
   logic [COL_W-1:0]    rsp_cursor_col;
   logic [POS_W-1:0]    rsp_cursor_pos;
   logic [CELL_W-1:0]   rsp_cell_data;

   logic [CELL_W-1:0]   screen_image [CELL_COUNT];
   int unsigned         model_row;
   int unsigned         model_col;
   logic [COLOR_W-1:0]  model_color;

   console_cmd_type     cmd_backlog [$];
   cursor_status_type   cursor_status_q [$];
   console_cmd_type     next_cmd;
   console_cmd_type     taken_cmd;
   cursor_status_type   taken_status;
   cursor_status_type   want;

   int                  burst_left = 4;
   int                  gap_left = 0;
   int                  stall_left = 0;
   int                  stall_mode = 0;
   int                  quiet_cycles = 0;
   int                  sent_count = 0;
   int                  checked_count = 0;
   int                  error_count = 0;
   int                  scroll_count = 0;
   int                  clear_count = 0;
   int                  color_writes = 0;

   text_console_cursor_engine u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_ch         (req_ch),
      .req_row        (req_row),
      .req_col        (req_col),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_data  (rsp_cell_data)
   );

   always #CLK_HALF clock = ~clock;

   function automatic logic [CELL_W-1:0] colored(input logic [CH_W-1:0] c);
      return {model_color, c};
   endfunction

   task automatic scroll_image();
      for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
         screen_image[i] = screen_image[i + COLUMNS];
      end
      for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
         screen_image[i] = colored(CH_BLANK);
      end
      model_row = ROWS - 1;
      scroll_count++;
   endtask

   task automatic advance_console(input console_cmd_type c, output cursor_status_type s);
      logic              in_bounds;
      logic [CELL_W-1:0] data;
      int unsigned       target;
      in_bounds = (int'(c.row) < ROWS) && (int'(c.col) < COLUMNS);
      target = int'(c.row) * COLUMNS + int'(c.col);
      data = '0;
      case (c.cmd)
         CMD_PUT_CHAR: begin
            if (c.ch == CH_NEWLINE) begin
               model_col = 0;
               model_row++;
            end else if (c.ch == CH_RETURN) begin
               model_col = 0;
            end else if (c.ch == CH_TAB) begin
               model_col = (model_col + TAB_STEP) & ~(TAB_STEP - 1);
            end else if (c.ch == CH_BACKSPACE) begin
               if (model_col > 0) begin
                  model_col--;
                  screen_image[model_row * COLUMNS + model_col] = colored(CH_BLANK);
               end
            end else begin
               screen_image[model_row * COLUMNS + model_col] = colored(c.ch);
               model_col++;
            end
            if (model_col >= COLUMNS) begin
               model_col = 0;
               model_row++;
            end
            if (model_row >= ROWS) begin
               scroll_image();
            end
         end
         CMD_CLEAR: begin
            for (int i = 0; i < CELL_COUNT; i++) begin
               screen_image[i] = colored(CH_BLANK);
            end
            model_row = 0;
            model_col = 0;
            clear_count++;
         end
         CMD_SET_CURSOR: begin
            if (in_bounds) begin
               model_row = c.row;
               model_col = c.col;
            end
         end
         CMD_PUT_AT: begin
            if (in_bounds) begin
               screen_image[target] = colored(c.ch);
            end
         end
         CMD_READ_CELL: begin
            if (in_bounds) begin
               data = screen_image[target];
            end
         end
         default: begin
         end
      endcase
      s.row = ROW_W'(model_row);
      s.col = COL_W'(model_col);
      s.pos = POS_W'(model_row * COLUMNS + model_col);
      s.cell_data = data;
   endtask

   // The request driver keeps one nonblocking update per signal per edge and
   // predicts each transaction at the edge where it is accepted.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         taken_cmd.cmd = req_cmd;
         taken_cmd.ch  = req_ch;
         taken_cmd.row = req_row;
         taken_cmd.col = req_col;
         advance_console(taken_cmd, taken_status);
         cursor_status_q.push_back(taken_status);
         if (burst_left > 0) begin
            burst_left--;
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
         end
      end
      if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (cmd_backlog.size() != 0) begin
            next_cmd = cmd_backlog.pop_front();
            req_valid <= 1'b1;
            req_cmd   <= next_cmd.cmd;
            req_ch    <= next_cmd.ch;
            req_row   <= next_cmd.row;
            req_col   <= next_cmd.col;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(8, 40);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 1) != 0);
         default: rsp_ready <= (stall_left % 3 == 0);
      endcase
   end

   function automatic void check_field(input string field, input int unsigned exp_value,
                                       input int unsigned act_value);
      if (exp_value != act_value) begin
         $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)", $time,
                  field, exp_value, exp_value, act_value, act_value);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (cursor_status_q.size() == 0) begin
            $display("%0t: response with no command outstanding, expected none, ",
                     "actual row %0d col %0d", $time, rsp_cursor_row, rsp_cursor_col);
            error_count++;
         end else begin
            want = cursor_status_q.pop_front();
            check_field("cursor_row", want.row, rsp_cursor_row);
            check_field("cursor_col", want.col, rsp_cursor_col);
            check_field("cursor_pos", want.pos, rsp_cursor_pos);
            check_field("cell_data", want.cell_data, rsp_cell_data);
            checked_count++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch,
                            input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
      console_cmd_type c;
      c.cmd = cmd;
      c.ch  = ch;
      c.row = row;
      c.col = col;
      do @(negedge clock); while (cmd_backlog.size() > 1);
      cmd_backlog.push_back(c);
      sent_count++;
   endtask

   task automatic drain();
      while (cmd_backlog.size() != 0 || req_valid || cursor_status_q.size() != 0 || !req_ready)
         @(negedge clock);
   endtask

   task automatic write_color(input logic [COLOR_W-1:0] value);
      drain();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      model_color = value;
      color_writes++;
   endtask

   function automatic logic [CH_W-1:0] typed_char();
      case ($urandom_range(0, 19))
         0: return CH_NEWLINE;
         1: return CH_RETURN;
         2: return CH_TAB;
         3: return CH_BACKSPACE;
         4: return CH_W'($urandom_range(0, 255));
         default: return CH_W'($urandom_range(32, 126));
      endcase
   endfunction

   function automatic logic [ROW_W-1:0] pick_row();
      if ($urandom_range(0, 7) == 0) begin
         return ROW_W'($urandom_range(ROWS, ROW_MAX));
      end
      return ROW_W'($urandom_range(0, ROWS - 1));
   endfunction

   function automatic logic [COL_W-1:0] pick_col();
      if ($urandom_range(0, 7) == 0) begin
         return COL_W'($urandom_range(COLUMNS, COL_MAX));
      end
      return COL_W'($urandom_range(0, COLUMNS - 1));
   endfunction

   // A freshly reset screen reads back as zero in its first and last cells and
   // out of range, and unused command codes leave the cursor alone.
   task automatic test_reset_state();
      send_item(CMD_READ_CELL, 8'h00, 5'd0, 7'd0);
      send_item(CMD_READ_CELL, 8'h00, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
      send_item(CMD_READ_CELL, 8'h00, ROW_W'(ROWS), 7'd0);
      send_item(CMD_READ_CELL, 8'hFF, ROW_W'(ROW_MAX), COL_W'(COL_MAX));
      send_item(CMD_SPARE_HIGH, 8'hFF, ROW_W'(ROW_MAX), COL_W'(COL_MAX));
      send_item(CMD_SPARE_LOW, 8'h00, 5'd0, 7'd0);
   endtask

   task automatic test_put_char_controls();
      send_item(CMD_PUT_CHAR, 8'h41, 5'd0, 7'd0);
      send_item(CMD_PUT_CHAR, 8'hFF, 5'd0, 7'd0);
      send_item(CMD_PUT_CHAR, 8'h00, 5'd0, 7'd0);
      send_item(CMD_PUT_CHAR, CH_TAB, 5'd0, 7'd0);
      send_item(CMD_PUT_CHAR, CH_BACKSPACE, 5'd0, 7'd0);
      send_item(CMD_PUT_CHAR, CH_RETURN, 5'd0, 7'd0);
      send_item(CMD_PUT_CHAR, CH_BACKSPACE, 5'd0, 7'd0);
      send_item(CMD_PUT_CHAR, CH_NEWLINE, 5'd0, 7'd0);
      send_item(CMD_READ_CELL, 8'h00, 5'd0, 7'd0);
   endtask

   // On the last row, a character or tab that wraps at the right edge and a newline all scroll.
   task automatic test_screen_edges();
      send_item(CMD_SET_CURSOR, 8'h00, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
      send_item(CMD_PUT_CHAR, 8'h5A, 5'd0, 7'd0);
      send_item(CMD_SET_CURSOR, 8'h00, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 2));
      send_item(CMD_PUT_CHAR, CH_TAB, 5'd0, 7'd0);
      send_item(CMD_PUT_CHAR, CH_NEWLINE, 5'd0, 7'd0);
      send_item(CMD_SET_CURSOR, 8'h00, ROW_W'(ROWS), 7'd3);
      send_item(CMD_SET_CURSOR, 8'h00, 5'd3, COL_W'(COLUMNS));
      send_item(CMD_PUT_AT, 8'h71, 5'd0, 7'd0);
      send_item(CMD_PUT_AT, 8'h71, ROW_W'(ROW_MAX), COL_W'(COL_MAX));
      send_item(CMD_READ_CELL, 8'h00, ROW_W'(ROWS - 4), COL_W'(COLUMNS - 1));
      send_item(CMD_CLEAR, 8'h00, 5'd0, 7'd0);
   endtask

   task automatic test_random_traffic(input int item_goal);
      int start_count;
      int next_break;
      int kind;
      int r;
      int c0;
      start_count = sent_count;
      next_break = start_count + 100;
      while (sent_count - start_count < item_goal) begin
         if (sent_count >= next_break) begin
            next_break += 100;
            write_color(COLOR_W'($urandom_range(0, 255)));
         end
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            r = $urandom_range(0, ROWS - 1);
            c0 = $urandom_range(0, COLUMNS - 1);
            send_item(CMD_SET_CURSOR, CH_W'($urandom), ROW_W'(r), COL_W'(c0));
            repeat ($urandom_range(1, 24))
               send_item(CMD_PUT_CHAR, typed_char(), ROW_W'($urandom), COL_W'($urandom));
            repeat ($urandom_range(1, 4))
               send_item(CMD_READ_CELL, 8'h00, ROW_W'(r),
                         COL_W'($urandom_range(COLUMNS - 1, c0)));
         end else if (kind < 55) begin
            r = pick_row();
            c0 = pick_col();
            send_item(CMD_PUT_AT, CH_W'($urandom), ROW_W'(r), COL_W'(c0));
            send_item(CMD_READ_CELL, CH_W'($urandom), ROW_W'(r), COL_W'(c0));
         end else if (kind < 75) begin
            send_item(CMD_W'($urandom_range(0, 7)), CH_W'($urandom), ROW_W'($urandom),
                      COL_W'($urandom));
         end else if (kind < 85) begin
            send_item(CMD_SET_CURSOR, CH_W'($urandom), pick_row(), pick_col());
            send_item(CMD_PUT_CHAR, typed_char(), 5'd0, 7'd0);
            send_item(CMD_READ_CELL, 8'h00, pick_row(), pick_col());
         end else if (kind < 93) begin
            send_item(CMD_SET_CURSOR, 8'h00, ROW_W'(ROWS - 1),
                      COL_W'($urandom_range(0, COLUMNS - 1)));
            repeat ($urandom_range(2, 12))
               send_item(CMD_PUT_CHAR, ($urandom_range(0, 5) == 0) ? CH_NEWLINE : typed_char(),
                         5'd0, 7'd0);
            send_item(CMD_READ_CELL, 8'h00, ROW_W'(ROWS - 2),
                      COL_W'($urandom_range(0, COLUMNS - 1)));
         end else if (kind < 95) begin
            send_item(CMD_CLEAR, CH_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
            repeat (3) send_item(CMD_READ_CELL, 8'h00, pick_row(), pick_col());
         end else begin
            r = $urandom_range(0, ROWS - 1);
            send_item(CMD_SET_CURSOR, 8'h00, ROW_W'(r), COL_W'($urandom_range(0, 6)));
            repeat ($urandom_range(1, 8))
               send_item(CMD_PUT_CHAR, CH_BACKSPACE, ROW_W'($urandom), COL_W'($urandom));
            send_item(CMD_READ_CELL, 8'h00, ROW_W'(r), COL_W'($urandom_range(0, 6)));
         end
      end
   endtask

   initial begin
      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_cmd   = '0;
      req_ch    = '0;
      req_row   = '0;
      req_col   = '0;
      csr_we    = 1'b0;
      csr_wdata = '0;
      rsp_ready = 1'b0;
      for (int i = 0; i < CELL_COUNT; i++) begin
         screen_image[i] = '0;
      end
      model_row   = 0;
      model_col   = 0;
      model_color = COLOR_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_put_char_controls();
      write_color(8'hFF);
      test_screen_edges();
      write_color(8'h00);
      test_random_traffic(600);

      drain();
      repeat (10) @(posedge clock);
      $display("Run summary: %0d commands sent and %0d responses checked, ",
               "with %0d scrolls and %0d clears.",
               sent_count, checked_count, scroll_count, clear_count);
      $display("The text color was programmed %0d times, including both extremes.", color_writes);
      if (error_count == 0 && cursor_status_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
